>>> design/gain_scheduled_lqr_feedback_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gain-scheduled LQR feedback block.
// Every module that uses them has i_clk and an active-low i_rst_n.
// ----------------------------------------------------------------------------
`ifndef GAIN_SCHEDULED_LQR_FEEDBACK_MACROS_SVH
`define GAIN_SCHEDULED_LQR_FEEDBACK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GSLQR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GSLQR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gslqr_pkg.sv
// ----------------------------------------------------------------------------
// gslqr_pkg
// Shared widths, codes, item types and fixed-point helpers of the
// gain-scheduled LQR feedback pipeline.
// ----------------------------------------------------------------------------
package gslqr_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_W        = 16;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int SUM_W         = 48;
    localparam int LEN_W         = 17;
    localparam int IDX_W         = 6;
    localparam int HALF_W        = 31;
    localparam int NUM_WORDS     = 48;
    localparam int NUM_TERMS     = 4;
    localparam int NUM_MUL_TERMS = 3;
    localparam int CONST_TERM    = 3;
    localparam int NUM_ROWS      = 12;
    localparam int NUM_STATES    = 6;
    localparam int NUM_OUTPUTS   = 2;
    localparam int DIST_STATE    = 2;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } t_opcode;

    localparam t_word WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [PROD_W:0] HALF_LSB =
        {{(PROD_W-FRAC_W+1){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

    // Item leaving the schedule stages: load fields plus leg powers and errors.
    typedef struct packed {
        t_opcode                 op;
        logic [IDX_W-1:0]        idx;
        t_word                   value;
        t_word                   len;
        t_word                   pw1;
        t_word                   pw0;
        t_word [NUM_STATES-1:0]  err;
    } t_sched_item;

    // Item leaving the gain stages: twelve gains and the error vector.
    typedef struct packed {
        t_word [NUM_ROWS-1:0]    gain;
        t_word [NUM_STATES-1:0]  err;
    } t_gain_item;

    // Clamp a wide signed value to one data word.
    function automatic t_word sat_word(input logic signed [SUM_W-1:0] x);
        if (x[SUM_W-1:DATA_W-1] == '0 || x[SUM_W-1:DATA_W-1] == '1) begin
            return x[DATA_W-1:0];
        end else if (x[SUM_W-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

    // Exact product of two data words.
    function automatic t_prod mul_word(input t_word a, input t_word b);
        return a * b;
    endfunction

    // Round a full product to the fixed-point grid (halves go up), then clamp.
    function automatic t_word round_sat(input t_prod p);
        logic signed [PROD_W:0] s;
        s = {p[PROD_W-1], p} + HALF_LSB;
        return sat_word(s[FRAC_W+SUM_W-1:FRAC_W]);
    endfunction

endpackage

>>> design/gain_scheduled_lqr_feedback.sv
// ----------------------------------------------------------------------------
// gain_scheduled_lqr_feedback
//
// Gain-scheduled LQR state feedback for a wheeled biped leg, in Q16.16.
// Load items (opcode 0) write one word of the 48-word coefficient table and
// give no result; compute items (opcode 1) give one result each. The block
// accepts one item per clock cycle while no output stall backs up to the
// input, loads and computes mixed freely. A compute result passes through
// the register stages A to L and is presented from the output register. The
// rate is set by the pipeline: every stage holds one item, and each
// multiplication has its own lane (twelve gain lanes of three multipliers,
// twelve gain-by-error multipliers), so no unit is shared between items. A
// load takes effect for every compute that follows it in the input stream.
// Table words have no reset value: load every word before the first compute.
// ----------------------------------------------------------------------------

// Pipeline map (one register stage per letter):
//   A-E  gslqr_sched  : input register, L^2, L^3, error vector
//   F-H  gslqr_gain   : table write for loads, coefficient products, gain sums
//   I-L  gslqr_torque : gain times error, torque totals, output register
// Each stage has its own valid bit, and a stage takes a new item whenever it
// is empty or its own item moves on, so bubbles close up and the input keeps
// flowing while a finished result waits at the output, as long as an empty
// stage remains. The stall seen at the input is a combinational function of
// the stage valid bits and the output stall.

module gain_scheduled_lqr_feedback (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Input channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_opcode,
    input  logic [5:0]          i_coeff_index,
    input  logic signed [31:0]  i_coeff_value,
    input  logic [16:0]         i_leg_length,
    input  logic signed [31:0]  i_leg_angle,
    input  logic signed [31:0]  i_leg_angle_rate,
    input  logic signed [31:0]  i_distance,
    input  logic signed [31:0]  i_distance_rate,
    input  logic signed [31:0]  i_body_pitch,
    input  logic signed [31:0]  i_body_pitch_rate,
    input  logic signed [31:0]  i_distance_target,

    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_wheel_torque_total,
    output logic signed [31:0]  o_hip_torque_total,
    output logic signed [30:0]  o_wheel_torque_per_leg,
    output logic signed [31:0]  o_hip_torque_per_leg
);

    // The six states in the order that the gain table rows use.
    gslqr_pkg::t_word [gslqr_pkg::NUM_STATES-1:0] state_vec;

    logic                   sched_valid;
    logic                   sched_stall;
    gslqr_pkg::t_sched_item sched_item;

    logic                   gain_valid;
    logic                   gain_stall;
    gslqr_pkg::t_gain_item  gain_item;

    assign state_vec = {i_body_pitch_rate, i_body_pitch, i_distance_rate,
                        i_distance, i_leg_angle_rate, i_leg_angle};

    // Leg powers and the error vector. Load items ride along unchanged so that
    // they reach the table in order with the computes around them.
    gslqr_sched u_sched (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in_valid),
        .o_stall           (o_in_stall),
        .i_opcode          (i_opcode),
        .i_coeff_index     (i_coeff_index),
        .i_coeff_value     (i_coeff_value),
        .i_leg_length      (i_leg_length),
        .i_state           (state_vec),
        .i_distance_target (i_distance_target),
        .o_valid           (sched_valid),
        .i_stall           (sched_stall),
        .o_item            (sched_item)
    );

    // Coefficient table and gain schedule. A load transfer into this stage
    // writes the table and is retired there; an index past the table is
    // dropped.
    gslqr_gain u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sched_valid),
        .o_stall  (sched_stall),
        .i_item   (sched_item),
        .o_valid  (gain_valid),
        .i_stall  (gain_stall),
        .o_item   (gain_item)
    );

    // Torque totals saturate to 32 bits; the per-leg values are the floor of
    // half the wheel total and of half the negated hip total.
    gslqr_torque u_torque (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (gain_valid),
        .o_stall                (gain_stall),
        .i_item                 (gain_item),
        .o_valid                (o_out_valid),
        .i_stall                (i_out_stall),
        .o_wheel_torque_total   (o_wheel_torque_total),
        .o_hip_torque_total     (o_hip_torque_total),
        .o_wheel_torque_per_leg (o_wheel_torque_per_leg),
        .o_hip_torque_per_leg   (o_hip_torque_per_leg)
    );

endmodule

>>> design/gslqr_sched.sv
// ----------------------------------------------------------------------------
// gslqr_sched
// Input register, leg-length powers L^2 and L^3, and the error vector.
// Five stages; load items pass through untouched.
// ----------------------------------------------------------------------------
`include "gain_scheduled_lqr_feedback_macros.svh"

module gslqr_sched (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_stall,
    input  logic                                            i_opcode,
    input  logic [gslqr_pkg::IDX_W-1:0]                     i_coeff_index,
    input  logic signed [gslqr_pkg::DATA_W-1:0]             i_coeff_value,
    input  logic [gslqr_pkg::LEN_W-1:0]                     i_leg_length,
    input  gslqr_pkg::t_word [gslqr_pkg::NUM_STATES-1:0]    i_state,
    input  logic signed [gslqr_pkg::DATA_W-1:0]             i_distance_target,
    output logic                                            o_valid,
    input  logic                                            i_stall,
    output gslqr_pkg::t_sched_item                          o_item
);

    localparam int STAGES = 5;
    localparam int SW     = gslqr_pkg::SUM_W;
    localparam int NS     = gslqr_pkg::NUM_STATES;
    localparam int LW     = gslqr_pkg::LEN_W;
    localparam int DW     = gslqr_pkg::DATA_W;
    localparam int PW     = gslqr_pkg::PROD_W;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    logic [STAGES-1:0] rdy;

    // Stage A: registered input.
    gslqr_pkg::t_opcode       r_a_op;
    logic [gslqr_pkg::IDX_W-1:0] r_a_idx;
    gslqr_pkg::t_word         r_a_val;
    logic [LW-1:0]            r_a_len;
    gslqr_pkg::t_word         r_a_x [NS];
    gslqr_pkg::t_word         r_a_tgt;

    // Stage B: square of the leg length, errors.
    gslqr_pkg::t_opcode       r_b_op;
    logic [gslqr_pkg::IDX_W-1:0] r_b_idx;
    gslqr_pkg::t_word         r_b_val;
    logic [LW-1:0]            r_b_len;
    logic [2*LW-1:0]          r_b_sq;
    gslqr_pkg::t_word         r_b_err [NS];

    // Stage C: rounded L^2.
    gslqr_pkg::t_opcode       r_c_op;
    logic [gslqr_pkg::IDX_W-1:0] r_c_idx;
    gslqr_pkg::t_word         r_c_val;
    logic [LW-1:0]            r_c_len;
    gslqr_pkg::t_word         r_c_pw1;
    gslqr_pkg::t_word         r_c_err [NS];

    // Stage D: full product L^2 * L.
    gslqr_pkg::t_opcode       r_d_op;
    logic [gslqr_pkg::IDX_W-1:0] r_d_idx;
    gslqr_pkg::t_word         r_d_val;
    logic [LW-1:0]            r_d_len;
    gslqr_pkg::t_word         r_d_pw1;
    gslqr_pkg::t_prod         r_d_cube;
    gslqr_pkg::t_word         r_d_err [NS];

    // Stage E: rounded L^3.
    gslqr_pkg::t_opcode       r_e_op;
    logic [gslqr_pkg::IDX_W-1:0] r_e_idx;
    gslqr_pkg::t_word         r_e_val;
    logic [LW-1:0]            r_e_len;
    gslqr_pkg::t_word         r_e_pw1;
    gslqr_pkg::t_word         r_e_pw0;
    gslqr_pkg::t_word         r_e_err [NS];

    // A stage can take a new item when it is empty or its item moves on.
    always_comb begin
        rdy[STAGES-1] = !r_v[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        n_v[0] = rdy[0] ? i_valid : r_v[0];
        for (int k = 1; k < STAGES; k++) begin
            n_v[k] = rdy[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_a_op  <= gslqr_pkg::t_opcode'(i_opcode);
            r_a_idx <= i_coeff_index;
            r_a_val <= i_coeff_value;
            r_a_len <= i_leg_length;
            r_a_tgt <= i_distance_target;
            for (int j = 0; j < NS; j++) begin
                r_a_x[j] <= $signed(i_state[j]);
            end
        end
        if (rdy[1]) begin
            r_b_op  <= r_a_op;
            r_b_idx <= r_a_idx;
            r_b_val <= r_a_val;
            r_b_len <= r_a_len;
            r_b_sq  <= r_a_len * r_a_len;
            for (int j = 0; j < NS; j++) begin
                if (j == gslqr_pkg::DIST_STATE) begin
                    r_b_err[j] <= gslqr_pkg::sat_word(SW'(r_a_tgt) - SW'(r_a_x[j]));
                end else begin
                    r_b_err[j] <= gslqr_pkg::sat_word(-SW'(r_a_x[j]));
                end
            end
        end
        if (rdy[2]) begin
            r_c_op  <= r_b_op;
            r_c_idx <= r_b_idx;
            r_c_val <= r_b_val;
            r_c_len <= r_b_len;
            r_c_pw1 <= gslqr_pkg::round_sat({{(PW-2*LW){1'b0}}, r_b_sq});
            r_c_err <= r_b_err;
        end
        if (rdy[3]) begin
            r_d_op   <= r_c_op;
            r_d_idx  <= r_c_idx;
            r_d_val  <= r_c_val;
            r_d_len  <= r_c_len;
            r_d_pw1  <= r_c_pw1;
            r_d_cube <= gslqr_pkg::mul_word(r_c_pw1, {{(DW-LW){1'b0}}, r_c_len});
            r_d_err  <= r_c_err;
        end
        if (rdy[4]) begin
            r_e_op  <= r_d_op;
            r_e_idx <= r_d_idx;
            r_e_val <= r_d_val;
            r_e_len <= r_d_len;
            r_e_pw1 <= r_d_pw1;
            r_e_pw0 <= gslqr_pkg::round_sat(r_d_cube);
            r_e_err <= r_d_err;
        end
    end

    always_comb begin
        o_item.op    = r_e_op;
        o_item.idx   = r_e_idx;
        o_item.value = r_e_val;
        o_item.len   = {{(DW-LW){1'b0}}, r_e_len};
        o_item.pw1   = r_e_pw1;
        o_item.pw0   = r_e_pw0;
        for (int j = 0; j < NS; j++) begin
            o_item.err[j] = r_e_err[j];
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_stall = !rdy[0];

    // An empty entry stage must always take a transfer.
    `GSLQR_ASSERT_NOW(a_empty_entry_open, !r_v[0], !o_stall, "entry stall with empty stage")

endmodule

>>> design/gslqr_gain.sv
// ----------------------------------------------------------------------------
// gslqr_gain
// Coefficient table and gain schedule: twelve cubic polynomials in the leg
// length, one lane per gain. Three stages; load items end here.
// ----------------------------------------------------------------------------
`include "gain_scheduled_lqr_feedback_macros.svh"

module gslqr_gain (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  gslqr_pkg::t_sched_item  i_item,
    output logic                    o_valid,
    input  logic                    i_stall,
    output gslqr_pkg::t_gain_item   o_item
);

    localparam int STAGES = 3;
    localparam int SW     = gslqr_pkg::SUM_W;
    localparam int NR     = gslqr_pkg::NUM_ROWS;
    localparam int NS     = gslqr_pkg::NUM_STATES;
    localparam int NT     = gslqr_pkg::NUM_TERMS;
    localparam int NM     = gslqr_pkg::NUM_MUL_TERMS;
    localparam int IW     = gslqr_pkg::IDX_W;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    logic [STAGES-1:0] rdy;
    logic              accept;
    logic              load_acc;

    gslqr_pkg::t_word  r_table [gslqr_pkg::NUM_WORDS];
    gslqr_pkg::t_word  pw [NM];

    gslqr_pkg::t_prod  r_f_prod [NR][NM];
    gslqr_pkg::t_word  r_f_c3   [NR];
    gslqr_pkg::t_word  r_f_err  [NS];

    gslqr_pkg::t_word  r_g_term [NR][NM];
    gslqr_pkg::t_word  r_g_c3   [NR];
    gslqr_pkg::t_word  r_g_err  [NS];

    gslqr_pkg::t_word  r_h_gain [NR];
    gslqr_pkg::t_word  r_h_err  [NS];

    always_comb begin
        rdy[STAGES-1] = !r_v[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        accept   = i_valid && rdy[0];
        load_acc = accept && (i_item.op == gslqr_pkg::OP_LOAD);
        // Only compute items occupy the gain stages.
        n_v[0] = rdy[0] ? (i_valid && (i_item.op == gslqr_pkg::OP_COMPUTE)) : r_v[0];
        for (int k = 1; k < STAGES; k++) begin
            n_v[k] = rdy[k] ? r_v[k-1] : r_v[k];
        end
        pw[0] = $signed(i_item.pw0);
        pw[1] = $signed(i_item.pw1);
        pw[2] = $signed(i_item.len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // Loads write in item order, so a compute behind a load sees the new word.
    always_ff @(posedge i_clk) begin
        if (load_acc && (i_item.idx < IW'(gslqr_pkg::NUM_WORDS))) begin
            r_table[i_item.idx] <= $signed(i_item.value);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int r = 0; r < NR; r++) begin
                for (int t = 0; t < NM; t++) begin
                    r_f_prod[r][t] <= gslqr_pkg::mul_word(r_table[r*NT+t], pw[t]);
                end
                r_f_c3[r] <= r_table[r*NT+gslqr_pkg::CONST_TERM];
            end
            for (int j = 0; j < NS; j++) begin
                r_f_err[j] <= $signed(i_item.err[j]);
            end
        end
        if (rdy[1]) begin
            for (int r = 0; r < NR; r++) begin
                for (int t = 0; t < NM; t++) begin
                    r_g_term[r][t] <= gslqr_pkg::round_sat(r_f_prod[r][t]);
                end
            end
            r_g_c3  <= r_f_c3;
            r_g_err <= r_f_err;
        end
        if (rdy[2]) begin
            for (int r = 0; r < NR; r++) begin
                r_h_gain[r] <= gslqr_pkg::sat_word(SW'(r_g_term[r][0]) + SW'(r_g_term[r][1])
                                                 + SW'(r_g_term[r][2]) + SW'(r_g_c3[r]));
            end
            r_h_err <= r_g_err;
        end
    end

    always_comb begin
        for (int r = 0; r < NR; r++) begin
            o_item.gain[r] = r_h_gain[r];
        end
        for (int j = 0; j < NS; j++) begin
            o_item.err[j] = r_h_err[j];
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_stall = !rdy[0];

    // A load never becomes a result: it must not fill an empty first stage.
    `GSLQR_ASSERT_NEXT(a_load_no_item, load_acc && !r_v[0], !r_v[0], "load entered gain stages")
    // An in-range load lands in the addressed word.
    `GSLQR_ASSERT_NEXT(a_load_written, load_acc && (i_item.idx < IW'(gslqr_pkg::NUM_WORDS)), r_table[$past(i_item.idx)] == $signed($past(i_item.value)), "coefficient write lost")

endmodule

>>> design/gslqr_torque.sv
// ----------------------------------------------------------------------------
// gslqr_torque
// Gain times error, row sums into the two torque totals, and the per-leg
// values. Four stages, the last one is the output register.
// ----------------------------------------------------------------------------
`include "gain_scheduled_lqr_feedback_macros.svh"

module gslqr_torque (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  gslqr_pkg::t_gain_item                       i_item,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic signed [gslqr_pkg::DATA_W-1:0]         o_wheel_torque_total,
    output logic signed [gslqr_pkg::DATA_W-1:0]         o_hip_torque_total,
    output logic signed [gslqr_pkg::HALF_W-1:0]         o_wheel_torque_per_leg,
    output logic signed [gslqr_pkg::DATA_W-1:0]         o_hip_torque_per_leg
);

    localparam int STAGES = 4;
    localparam int SW     = gslqr_pkg::SUM_W;
    localparam int DW     = gslqr_pkg::DATA_W;
    localparam int NR     = gslqr_pkg::NUM_ROWS;
    localparam int NS     = gslqr_pkg::NUM_STATES;
    localparam int NO     = gslqr_pkg::NUM_OUTPUTS;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    logic [STAGES-1:0] rdy;

    gslqr_pkg::t_prod  r_i_prod [NR];
    gslqr_pkg::t_word  r_j_term [NR];
    gslqr_pkg::t_word  r_k_tot  [NO];
    logic signed [SW-1:0] row_sum [NO];
    logic signed [DW:0]   hip_neg;

    gslqr_pkg::t_word                  r_l_wheel;
    gslqr_pkg::t_word                  r_l_hip;
    logic signed [gslqr_pkg::HALF_W-1:0] r_l_wheel_half;
    gslqr_pkg::t_word                  r_l_hip_half;

    always_comb begin
        rdy[STAGES-1] = !r_v[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        n_v[0] = rdy[0] ? i_valid : r_v[0];
        for (int k = 1; k < STAGES; k++) begin
            n_v[k] = rdy[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // Row j*2+r of the table is the gain of state j on output r.
    always_comb begin
        for (int r = 0; r < NO; r++) begin
            row_sum[r] = '0;
            for (int j = 0; j < NS; j++) begin
                row_sum[r] = row_sum[r] + SW'(r_j_term[j*NO+r]);
            end
        end
        hip_neg = -{r_k_tot[1][DW-1], r_k_tot[1]};
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int r = 0; r < NR; r++) begin
                r_i_prod[r] <= gslqr_pkg::mul_word($signed(i_item.gain[r]),
                                                   $signed(i_item.err[r/NO]));
            end
        end
        if (rdy[1]) begin
            for (int r = 0; r < NR; r++) begin
                r_j_term[r] <= gslqr_pkg::round_sat(r_i_prod[r]);
            end
        end
        if (rdy[2]) begin
            for (int r = 0; r < NO; r++) begin
                r_k_tot[r] <= gslqr_pkg::sat_word(row_sum[r]);
            end
        end
        if (rdy[3]) begin
            r_l_wheel      <= r_k_tot[0];
            r_l_hip        <= r_k_tot[1];
            r_l_wheel_half <= r_k_tot[0][DW-1:1];
            r_l_hip_half   <= hip_neg[DW:1];
        end
    end

    assign o_valid                = r_v[STAGES-1];
    assign o_stall                = !rdy[0];
    assign o_wheel_torque_total   = r_l_wheel;
    assign o_hip_torque_total     = r_l_hip;
    assign o_wheel_torque_per_leg = r_l_wheel_half;
    assign o_hip_torque_per_leg   = r_l_hip_half;

    // A held result and the item behind it both survive a stalled cycle.
    `GSLQR_ASSERT_NEXT(a_stall_keeps_items, r_v[2] && r_v[3] && i_stall, r_v[2] && r_v[3], "item lost under stall")
    // An item ready for an empty output register moves into it.
    `GSLQR_ASSERT_NEXT(a_output_fills, r_v[2] && !r_v[3], r_v[3], "output register not filled")

endmodule
